/* rtl/bru_pkg.sv */
// ----------------------------------------------------------------------------
// bru_pkg
// Shared types, constants and helpers for the bitmap row unpacker.
// ----------------------------------------------------------------------------
package bru_pkg;

    localparam int MAX_ROW_PIXELS_DEF = 4096;
    localparam int PALETTE_DEPTH_DEF  = 256;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 3;
    localparam int WIDTH_REG_W = 13;

    localparam logic [0:0] REG_DEPTH_MODE = 1'b0;
    localparam logic [0:0] REG_ROW_WIDTH  = 1'b1;

    localparam logic [MODE_W-1:0]      DEPTH_MODE_RST = 3'd2;
    localparam logic [WIDTH_REG_W-1:0] ROW_WIDTH_RST  = 13'd1;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    typedef enum logic [2:0] {
        DEPTH_1BPP  = 3'd0,
        DEPTH_4BPP  = 3'd1,
        DEPTH_8BPP  = 3'd2,
        DEPTH_16BPP = 3'd3,
        DEPTH_24BPP = 3'd4,
        DEPTH_32BPP = 3'd5
    } t_depth;

    typedef enum logic [1:0] {
        JOB_PAL_WRITE = 2'd0,
        JOB_INDEX     = 2'd1,
        JOB_DIRECT    = 2'd2
    } t_job_kind;

    typedef struct packed {
        logic       command;
        logic [7:0] palette_slot;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       last_of_item;
    } t_out_item;

    // data: palette rgb, direct pixel rgb, or raw byte in [7:0]
    typedef struct packed {
        t_job_kind   kind;
        t_depth      depth;
        logic [23:0] data;
        logic [7:0]  slot;
        logic [2:0]  cnt_m1;
        logic        row_end;
    } t_job;

    typedef struct packed {
        t_depth                 depth;
        logic [WIDTH_REG_W-1:0] width;
        logic                   restart;
    } t_row_cfg;

    function automatic t_depth eff_depth(input logic [MODE_W-1:0] raw);
        t_depth d;
        case (raw)
            3'd0: d = DEPTH_1BPP;
            3'd1: d = DEPTH_4BPP;
            3'd3: d = DEPTH_16BPP;
            3'd4: d = DEPTH_24BPP;
            3'd5: d = DEPTH_32BPP;
            default: d = DEPTH_8BPP;
        endcase
        return d;
    endfunction

    // 5-bit to 8-bit ramp: 0 -> 0, 31 -> 255, else 8n+8
    function automatic logic [7:0] ramp5(input logic [4:0] n);
        logic [7:0] v;
        if (n == 5'd0) begin
            v = 8'd0;
        end else if (n == 5'd31) begin
            v = 8'd255;
        end else begin
            v = {n, 3'b000} + 8'd8;
        end
        return v;
    endfunction

endpackage

/* rtl/bru_ram.sv */
// ----------------------------------------------------------------------------
// bru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bru_front.sv */
// ----------------------------------------------------------------------------
// bru_front
// Accepts items, tracks row position and padding, assembles multi-byte
// pixels and issues jobs to the queue.
// ----------------------------------------------------------------------------
module bru_front #(
    parameter int MAX_ROW_PIXELS = bru_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bru_pkg::t_row_cfg i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  bru_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output bru_pkg::t_job     o_job
);
    import bru_pkg::*;

    localparam int PIX_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int BYTE_W = $clog2(4 * MAX_ROW_PIXELS + 1);

    logic [BYTE_W-1:0] r_bpos, n_bpos;
    logic [PIX_W-1:0]  r_pos, n_pos;
    logic [23:0]       r_partial, n_partial;
    logic [1:0]        r_bip, n_bip;

    logic              accept;
    logic [PIX_W-1:0]  w_eff;
    logic [BYTE_W-1:0] u_w;
    logic [BYTE_W-1:0] used;
    logic [BYTE_W-1:0] total;
    logic [PIX_W-1:0]  left;
    logic              in_row;
    logic              mk_index;
    logic              mk_direct;
    logic [23:0]       direct_rgb;
    logic [3:0]        pix_cnt;
    logic [15:0]       word;

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign word    = {i_item.data_byte, r_partial[7:0]};

    always_comb begin
        if (32'(i_cfg.width) > 32'(MAX_ROW_PIXELS)) begin
            w_eff = PIX_W'(MAX_ROW_PIXELS);
        end else if (i_cfg.width == '0) begin
            w_eff = PIX_W'(1);
        end else begin
            w_eff = PIX_W'(i_cfg.width);
        end
        u_w = BYTE_W'(w_eff);
        case (i_cfg.depth)
            DEPTH_1BPP:  used = (u_w + BYTE_W'(7)) >> 3;
            DEPTH_4BPP:  used = (u_w + BYTE_W'(1)) >> 1;
            DEPTH_16BPP: used = u_w << 1;
            DEPTH_24BPP: used = (u_w << 1) + u_w;
            DEPTH_32BPP: used = u_w << 2;
            default:     used = u_w;
        endcase
        total  = (used + BYTE_W'(3)) & ~BYTE_W'(3);
        left   = (r_pos < w_eff) ? (w_eff - r_pos) : '0;
        in_row = (r_bpos < used) && (r_pos < w_eff);
    end

    always_comb begin
        n_bpos     = r_bpos;
        n_pos      = r_pos;
        n_partial  = r_partial;
        n_bip      = r_bip;
        mk_index   = 1'b0;
        mk_direct  = 1'b0;
        direct_rgb = '0;
        pix_cnt    = '0;
        o_push     = 1'b0;
        o_job      = '0;

        if (accept) begin
            if (i_item.command == CMD_PALETTE) begin
                o_push      = 1'b1;
                o_job.kind  = JOB_PAL_WRITE;
                o_job.slot  = i_item.palette_slot;
                o_job.data  = {i_item.palette_red, i_item.palette_green,
                               i_item.palette_blue};
            end else begin
                if (in_row) begin
                    case (i_cfg.depth)
                        DEPTH_1BPP: begin
                            mk_index = 1'b1;
                            pix_cnt  = (left >= PIX_W'(8)) ? 4'd8 : 4'(left);
                        end
                        DEPTH_4BPP: begin
                            mk_index = 1'b1;
                            pix_cnt  = (left > PIX_W'(1)) ? 4'd2 : 4'd1;
                        end
                        DEPTH_16BPP: begin
                            if (r_bip == 2'd0) begin
                                n_partial[7:0] = i_item.data_byte;
                                n_bip          = 2'd1;
                            end else begin
                                mk_direct  = 1'b1;
                                direct_rgb = {ramp5(word[14:10]), ramp5(word[9:5]),
                                              ramp5(word[4:0])};
                            end
                        end
                        DEPTH_24BPP: begin
                            if (r_bip < 2'd2) begin
                                n_partial[8*r_bip +: 8] = i_item.data_byte;
                                n_bip = r_bip + 2'd1;
                            end else begin
                                mk_direct  = 1'b1;
                                direct_rgb = {i_item.data_byte, r_partial[15:0]};
                            end
                        end
                        DEPTH_32BPP: begin
                            if (r_bip < 2'd3) begin
                                n_partial[8*r_bip +: 8] = i_item.data_byte;
                                n_bip = r_bip + 2'd1;
                            end else begin
                                mk_direct  = 1'b1;
                                direct_rgb = r_partial;
                            end
                        end
                        default: begin
                            mk_index = 1'b1;
                            pix_cnt  = 4'd1;
                        end
                    endcase
                end

                if (mk_direct) begin
                    pix_cnt   = 4'd1;
                    n_partial = '0;
                    n_bip     = '0;
                end

                o_push        = mk_index || mk_direct;
                o_job.kind    = mk_direct ? JOB_DIRECT : JOB_INDEX;
                o_job.depth   = i_cfg.depth;
                o_job.data    = mk_direct ? direct_rgb : {16'd0, i_item.data_byte};
                o_job.cnt_m1  = 3'(pix_cnt - 4'd1);
                o_job.row_end = (PIX_W'(pix_cnt) == left);

                n_bpos = r_bpos + BYTE_W'(1);
                n_pos  = r_pos + PIX_W'(pix_cnt);
                if ((r_bpos + BYTE_W'(1)) >= total) begin
                    n_bpos    = '0;
                    n_pos     = '0;
                    n_partial = '0;
                    n_bip     = '0;
                end
            end
        end

        if (i_cfg.restart) begin
            n_bpos    = '0;
            n_pos     = '0;
            n_partial = '0;
            n_bip     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos    <= '0;
            r_pos     <= '0;
            r_partial <= '0;
            r_bip     <= '0;
        end else begin
            r_bpos    <= n_bpos;
            r_pos     <= n_pos;
            r_partial <= n_partial;
            r_bip     <= n_bip;
        end
    end

endmodule

/* rtl/bru_job_queue.sv */
// ----------------------------------------------------------------------------
// bru_job_queue
// Short register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module bru_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bru_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output bru_pkg::t_job o_head,
    output logic          o_empty
);
    import bru_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/bru_back.sv */
// ----------------------------------------------------------------------------
// bru_back
// Executes jobs: palette writes, palette lookups one pixel per cycle unless the
// output stalls, direct pixels, and drives the output register.
// ----------------------------------------------------------------------------
module bru_back #(
    parameter int PALETTE_DEPTH = bru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bru_pkg::t_job      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bru_pkg::t_out_item o_out_item
);
    import bru_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    typedef struct packed {
        logic        direct;
        logic        blank;
        logic [23:0] rgb;
        logic        row_end;
        logic        last;
    } t_pix_meta;

    logic [2:0]  r_k;
    logic        r_b_valid;
    t_pix_meta   r_b_meta;
    logic        r_o_valid;
    t_out_item   r_o_item;

    logic        o_can, b_ready, head_pix, pal_wr, issue, last_px;
    logic [7:0]  idx;
    logic        ram_we, ram_re;
    logic [23:0] ram_rdata;

    always_comb begin
        o_can    = !r_o_valid || i_out_ready;
        b_ready  = !r_b_valid || o_can;
        head_pix = !i_empty && (i_head.kind != JOB_PAL_WRITE);
        pal_wr   = !i_empty && (i_head.kind == JOB_PAL_WRITE);
        issue    = head_pix && b_ready;
        last_px  = (r_k == i_head.cnt_m1);
        o_pop    = pal_wr || (issue && last_px);
        case (i_head.depth)
            DEPTH_1BPP: idx = {7'd0, i_head.data[3'd7 - r_k]};
            DEPTH_4BPP: idx = (r_k == 3'd0) ? {4'd0, i_head.data[7:4]}
                                            : {4'd0, i_head.data[3:0]};
            default:    idx = i_head.data[7:0];
        endcase
        ram_we = pal_wr && (9'(i_head.slot) < 9'(PALETTE_DEPTH));
        ram_re = issue && (i_head.kind == JOB_INDEX);
    end

    bru_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(i_head.slot)),
        .i_wdata(i_head.data),
        .i_re   (ram_re),
        .i_raddr(AW'(idx)),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= last_px ? 3'd0 : r_k + 3'd1;
            end
            if (b_ready) begin
                r_b_valid <= issue;
            end
            if (o_can) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_meta.direct  <= (i_head.kind == JOB_DIRECT);
            r_b_meta.blank   <= (9'(idx) >= 9'(PALETTE_DEPTH));
            r_b_meta.rgb     <= i_head.data;
            r_b_meta.row_end <= i_head.row_end && last_px;
            r_b_meta.last    <= last_px;
        end
        if (r_b_valid && o_can) begin
            if (r_b_meta.direct) begin
                {r_o_item.red, r_o_item.green, r_o_item.blue} <= r_b_meta.rgb;
            end else if (r_b_meta.blank) begin
                {r_o_item.red, r_o_item.green, r_o_item.blue} <= '0;
            end else begin
                {r_o_item.red, r_o_item.green, r_o_item.blue} <= ram_rdata;
            end
            r_o_item.row_end      <= r_b_meta.row_end;
            r_o_item.last_of_item <= r_b_meta.last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

/* rtl/bitmap_row_to_rgb888_unpacker.sv */
// ----------------------------------------------------------------------------
// bitmap_row_to_rgb888_unpacker
// Unpacks bitmap row bytes (1/4/8 bpp indexed, 16 bpp 555, 24/32 bpp) to
// RGB888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries palette writes and raw
//   row bytes, padding included. Output channel (o_out_valid/i_out_ready)
//   carries one pixel per item, with row_end and last_of_item flags.
//   Registers via APB: depth_mode at 0x0, row_width_pixels at 0x4; any
//   write restarts the current row.
//   Once the byte completing a pixel is accepted, the pixel passes through
//   the job queue, the palette read stage and the output register.
//   Throughput: one input item per cycle for 8, 16, 24 and 32 bpp and for
//   palette writes; unless the output stalls, the back end makes one pixel
//   per cycle through the palette read port, so a 1 bpp byte gives up to 8
//   pixels, a 4 bpp byte 2; input stalls when the four-entry job queue fills.
//   Reset clears row position, queue and output; palette contents are
//   undefined until written. A stalled receiver holds the output item;
//   the queue keeps taking input until full.
// ----------------------------------------------------------------------------
module bitmap_row_to_rgb888_unpacker #(
    parameter int MAX_ROW_PIXELS = bru_pkg::MAX_ROW_PIXELS_DEF,
    parameter int PALETTE_DEPTH  = bru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bru_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bru_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bru_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bru_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bru_pkg::t_out_item                 o_out_item
);
    import bru_pkg::*;

    logic [MODE_W-1:0]      r_depth_mode;
    logic [WIDTH_REG_W-1:0] r_row_width;
    logic                   cfg_wr;
    t_row_cfg               row_cfg;
    logic                   q_push, q_full, q_pop, q_empty;
    t_job                   q_in, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= DEPTH_MODE_RST;
            r_row_width  <= ROW_WIDTH_RST;
        end else if (cfg_wr) begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_DEPTH_MODE: r_depth_mode <= pwdata[MODE_W-1:0];
                REG_ROW_WIDTH:  r_row_width  <= pwdata[WIDTH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_DEPTH_MODE: prdata = CFG_DATA_W'(r_depth_mode);
            REG_ROW_WIDTH:  prdata = CFG_DATA_W'(r_row_width);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        row_cfg.depth   = eff_depth(r_depth_mode);
        row_cfg.width   = r_row_width;
        row_cfg.restart = cfg_wr;
    end

    bru_front #(
        .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (row_cfg),
        .i_valid(i_in_valid),
        .o_ready(o_in_ready),
        .i_item (i_in_item),
        .i_full (q_full),
        .o_push (q_push),
        .o_job  (q_in)
    );

    bru_job_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_empty(q_empty)
    );

    bru_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

/* rtl/bru_checker.sv */
// ----------------------------------------------------------------------------
// bru_checker
// Port-level checks for the bitmap row unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module bru_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           pready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input bru_pkg::t_out_item             o_out_item
);
    import bru_pkg::*;

    a_pready_high: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_row_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.row_end |-> o_out_item.last_of_item)
        else $error("row end pixel not last of its item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

endmodule

bind bitmap_row_to_rgb888_unpacker bru_checker u_bru_checker (.*);
